[design/edt_pkg.sv]
// shared constants, chain item type and helper functions for the edit distance check
package edt_pkg;

  // longest query kept, one cell per query position
  localparam int MAX_LEN = 64;
  localparam int POS_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int SYM_W   = 8;
  localparam int DIST_W  = 8;
  localparam int EDITS_W = 6;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // which_string codes
  localparam logic STR_QUERY     = 1'b0;
  localparam logic STR_CANDIDATE = 1'b1;

  // one slot of the wavefront moving down the cell chain
  typedef struct packed {
    logic              valid;
    logic              is_cand;   // candidate byte, else query byte
    logic              first;     // first byte of a candidate
    logic              last;      // last byte of a candidate
    logic              qstart;    // first byte of a new query
    logic [SYM_W-1:0]  sym;
    logic [POS_W-1:0]  pos;       // query position, counted down per cell
    logic [DIST_W-1:0] d_new;     // row value of the left column after this byte
    logic [DIST_W-1:0] d_old;     // row value of the left column before this byte
  } edt_item_t;

  // saturating increment of a row value
  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    return (v == DIST_MAX) ? v : v + DIST_W'(1);
  endfunction

  // smaller of two row values
  function automatic logic [DIST_W-1:0] dmin(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[design/edt_head.sv]
// input control and column zero of the distance row, feeds the cell chain
module edt_head (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     take,
  input  logic                     which_string,
  input  logic [edt_pkg::SYM_W-1:0] symbol,
  input  logic                     last_symbol,
  output edt_pkg::edt_item_t       item_out
);
  import edt_pkg::*;

  logic              query_closed;
  logic              candidate_open;
  logic [LEN_W-1:0]  query_length;
  logic [DIST_W-1:0] col0;

  logic [LEN_W-1:0]  len_base;
  logic              keep_byte;
  logic              cand_first;
  logic [DIST_W-1:0] col0_old;
  logic [DIST_W-1:0] col0_next;
  edt_item_t         item_next;

  // decode the incoming item
  always_comb begin
    len_base   = query_closed ? '0 : query_length;
    keep_byte  = (len_base < LEN_W'(MAX_LEN));
    cand_first = !candidate_open;
    col0_old   = cand_first ? '0 : col0;
    col0_next  = sat_inc(col0_old);

    item_next         = '0;
    item_next.sym     = symbol;
    item_next.last    = last_symbol;
    item_next.pos     = len_base[POS_W-1:0];
    item_next.qstart  = query_closed;
    item_next.first   = cand_first;
    item_next.d_old   = col0_old;
    item_next.d_new   = col0_next;
    if (take) begin
      if (which_string == STR_CANDIDATE) begin
        item_next.valid   = 1'b1;
        item_next.is_cand = 1'b1;
      end else begin
        // bytes beyond the last cell are dropped
        item_next.valid   = keep_byte;
      end
    end
  end

  // query and candidate bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      query_closed   <= 1'b1;
      candidate_open <= 1'b0;
      query_length   <= '0;
    end else if (en && take) begin
      if (which_string == STR_CANDIDATE) begin
        query_closed   <= 1'b1;
        candidate_open <= !last_symbol;
      end else begin
        candidate_open <= 1'b0;
        query_closed   <= last_symbol;
        query_length   <= len_base + LEN_W'(keep_byte);
      end
    end
  end

  // column zero value and launch register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= item_next.valid;
    end
    if (en) begin
      item_out.is_cand <= item_next.is_cand;
      item_out.first   <= item_next.first;
      item_out.last    <= item_next.last;
      item_out.qstart  <= item_next.qstart;
      item_out.sym     <= item_next.sym;
      item_out.pos     <= item_next.pos;
      item_out.d_new   <= item_next.d_new;
      item_out.d_old   <= item_next.d_old;
      if (take && which_string == STR_CANDIDATE) begin
        col0 <= col0_next;
      end
    end
  end

endmodule

[design/edt_cell.sv]
// one query position: holds its query byte and row value, updates one row entry per byte
module edt_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  edt_pkg::edt_item_t item_in,
  output edt_pkg::edt_item_t item_out
);
  import edt_pkg::*;

  logic [SYM_W-1:0]  qbyte;
  logic              active;
  logic [DIST_W-1:0] row_val;

  logic              hit;
  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] diag_cost;
  logic [DIST_W-1:0] new_val;

  // row recurrence for this position
  always_comb begin
    hit       = (item_in.pos == '0);
    // at candidate start this entry is its index, one above its left neighbor
    up        = item_in.first ? sat_inc(item_in.d_old) : row_val;
    diag_cost = (qbyte == item_in.sym) ? item_in.d_old : sat_inc(item_in.d_old);
    new_val   = dmin(diag_cost, dmin(sat_inc(up), sat_inc(item_in.d_new)));
  end

  always_ff @(posedge clk) begin
    // query load and active flag
    if (rst) begin
      active         <= 1'b0;
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= item_in.valid;
      if (item_in.valid && !item_in.is_cand) begin
        if (hit) begin
          active <= 1'b1;
        end else if (item_in.qstart) begin
          active <= 1'b0;
        end
      end
    end
    // stored values and hand-off to the next cell
    if (en) begin
      if (item_in.valid && !item_in.is_cand && hit) begin
        qbyte <= item_in.sym;
      end
      if (item_in.valid && item_in.is_cand && active) begin
        row_val <= new_val;
      end
      item_out.is_cand <= item_in.is_cand;
      item_out.first   <= item_in.first;
      item_out.last    <= item_in.last;
      item_out.qstart  <= item_in.qstart;
      item_out.sym     <= item_in.sym;
      item_out.pos     <= item_in.pos - POS_W'(1);
      // cells past the query end pass the row end through unchanged
      item_out.d_new   <= active ? new_val : item_in.d_new;
      item_out.d_old   <= active ? up : item_in.d_old;
    end
  end

endmodule

[design/edit_distance_threshold_check_unit.sv]
// top level: levenshtein distance of candidates against a stored query, with threshold
//
// Input channel (in_valid / in_ready) carries one byte per item: which_string selects
// query (0) or candidate (1), last_symbol closes the string. Query bytes load the cells;
// a new query starts on the first query byte after a closed query, and bytes past
// MAX_LEN are dropped. The last byte of a candidate produces one result on the output
// channel (out_valid / out_ready): edit_distance, saturated at 255, and is_match when
// it does not exceed max_edits, which is written through cfg_wr_en / cfg_wr_data.
// Throughput is one item per cycle, query and candidate bytes alike, while the output
// stall below does not hold the chain; it is set by the chain of MAX_LEN cells that
// each update one row entry per cycle as the byte wavefront passes. A result goes from
// the last candidate byte through the launch register, loaded at the accepting edge,
// then one stage per cell and the output register, independent of query length.
// When the receiver stalls, the chain keeps moving until a result reaches its end
// with the output register still full; then the whole chain and the input hold.
// Reset empties the chain, clears the stored query to length zero (distance equals
// candidate length) and sets max_edits to 2.
module edit_distance_threshold_check_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        which_string,
  input  logic [edt_pkg::SYM_W-1:0]   symbol,
  input  logic                        last_symbol,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        is_match,
  output logic [edt_pkg::DIST_W-1:0]  edit_distance,
  input  logic                        cfg_wr_en,
  input  logic [edt_pkg::EDITS_W-1:0] cfg_wr_data
);
  import edt_pkg::*;

  logic [EDITS_W-1:0] max_edits;
  edt_item_t          chain [MAX_LEN+1];
  edt_item_t          tail;
  logic               tail_result;
  logic               adv;

  // chain advance control
  assign tail        = chain[MAX_LEN];
  assign tail_result = tail.valid && tail.is_cand && tail.last;
  assign adv         = !(out_valid && !out_ready && tail_result);
  assign in_ready    = adv;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_edits <= EDITS_W'(2);
    end else if (cfg_wr_en) begin
      max_edits <= cfg_wr_data;
    end
  end

  // column zero and input control
  edt_head u_head (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .take         (in_valid),
    .which_string (which_string),
    .symbol       (symbol),
    .last_symbol  (last_symbol),
    .item_out     (chain[0])
  );

  // one cell per query position
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    edt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && tail_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_result) begin
      edit_distance <= tail.d_new;
      is_match      <= (tail.d_new <= DIST_W'(max_edits));
    end
  end

endmodule
